@@ src/analog_ladder_keypad_qualifier_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the analog ladder keypad qualifier
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ANALOG_LADDER_KEYPAD_QUALIFIER_TOP_MACROS_SVH
`define ANALOG_LADDER_KEYPAD_QUALIFIER_TOP_MACROS_SVH

// same-cycle implication
`define ALKQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ALKQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/alkq_pkg.sv @@
// ----------------------------------------------------------------------------
// Keypad qualifier package
// Types, decode thresholds, event codes and register indexes.
// ----------------------------------------------------------------------------
package alkq_pkg;

  localparam int CH_W   = 1;
  localparam int ADC_W  = 10;
  localparam int TIME_W = 32;
  localparam int DLY_W  = 16;
  localparam int SLOT_W = 3;
  localparam int MASK_W = 8;
  localparam int CIDX_W = 3;

  localparam logic [SLOT_W-1:0] NO_KEY = 3'd4;

  localparam logic [SLOT_W-1:0] SLOTS_TWO   = 3'd2;
  localparam logic [SLOT_W-1:0] SLOTS_THREE = 3'd3;
  localparam logic [SLOT_W-1:0] SLOTS_FOUR  = 3'd4;

  localparam logic [ADC_W-1:0] NONE_LIMIT = 10'd950;
  localparam logic [ADC_W-1:0] TWO_NONE   = 10'd760;
  localparam logic [ADC_W-1:0] TWO_LO     = 10'd256;
  localparam logic [ADC_W-1:0] THREE_NONE = 10'd852;
  localparam logic [ADC_W-1:0] THREE_LO   = 10'd170;
  localparam logic [ADC_W-1:0] THREE_MID  = 10'd511;
  localparam logic [ADC_W-1:0] FOUR_LO    = 10'd76;
  localparam logic [ADC_W-1:0] FOUR_MID   = 10'd352;
  localparam logic [ADC_W-1:0] FOUR_HI    = 10'd618;

  localparam logic [DLY_W-1:0]  DEBOUNCE_RST   = 16'd50;
  localparam logic [DLY_W-1:0]  LONG_RST       = 16'd1000;
  localparam logic [DLY_W-1:0]  REPEAT_RST     = 16'd300;
  localparam logic [TIME_W-1:0] INACTIVITY_RST = 32'd60000;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_DOWN   = 3'd1,
    EV_UP     = 3'd2,
    EV_LONG   = 3'd3,
    EV_REPEAT = 3'd4,
    EV_IDLE   = 3'd5
  } ev_kind_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_DEBOUNCE   = 3'd0,
    CFG_LONG       = 3'd1,
    CFG_REPEAT     = 3'd2,
    CFG_INACTIVITY = 3'd3,
    CFG_SLOTS_CH0  = 3'd4,
    CFG_SLOTS_CH1  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [DLY_W-1:0]  debounce;
    logic [DLY_W-1:0]  long_press;
    logic [DLY_W-1:0]  repeat_dly;
    logic [TIME_W-1:0] inactivity;
    logic [SLOT_W-1:0] slots_ch0;
    logic [SLOT_W-1:0] slots_ch1;
  } cfg_t;

  typedef struct packed {
    logic [SLOT_W-1:0] held;
    logic [TIME_W-1:0] bounce;
    logic [TIME_W-1:0] long_dl;
    logic [TIME_W-1:0] rpt;
  } chan_st_t;

  localparam chan_st_t CHAN_RST = '{held: NO_KEY, bounce: '0, long_dl: '0, rpt: '0};

  // one-hot key position: bit channel*4 + slot, nothing for no key
  function automatic logic [MASK_W-1:0] key_bit(logic [CH_W-1:0] ch,
                                                logic [SLOT_W-1:0] slot);
    logic [MASK_W-1:0] res;
    res = '0;
    if (slot < NO_KEY) begin
      res = MASK_W'(1) << {ch, slot[1:0]};
    end
    return res;
  endfunction

endpackage

@@ src/alkq_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Keypad qualifier configuration registers
// Delay and ladder-size registers written through the configuration channel.
// ----------------------------------------------------------------------------
module alkq_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [alkq_pkg::CIDX_W-1:0] cfg_index,
  input  logic [alkq_pkg::TIME_W-1:0] cfg_data,
  output alkq_pkg::cfg_t             cfg
);

  alkq_pkg::cfg_t cfg_r;
  alkq_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (alkq_pkg::cfg_idx_t'(cfg_index))
        alkq_pkg::CFG_DEBOUNCE:   cfg_nxt.debounce   = cfg_data[alkq_pkg::DLY_W-1:0];
        alkq_pkg::CFG_LONG:       cfg_nxt.long_press = cfg_data[alkq_pkg::DLY_W-1:0];
        alkq_pkg::CFG_REPEAT:     cfg_nxt.repeat_dly = cfg_data[alkq_pkg::DLY_W-1:0];
        alkq_pkg::CFG_INACTIVITY: cfg_nxt.inactivity = cfg_data;
        alkq_pkg::CFG_SLOTS_CH0:  cfg_nxt.slots_ch0  = cfg_data[alkq_pkg::SLOT_W-1:0];
        alkq_pkg::CFG_SLOTS_CH1:  cfg_nxt.slots_ch1  = cfg_data[alkq_pkg::SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce   <= alkq_pkg::DEBOUNCE_RST;
      cfg_r.long_press <= alkq_pkg::LONG_RST;
      cfg_r.repeat_dly <= alkq_pkg::REPEAT_RST;
      cfg_r.inactivity <= alkq_pkg::INACTIVITY_RST;
      cfg_r.slots_ch0  <= alkq_pkg::SLOTS_THREE;
      cfg_r.slots_ch1  <= alkq_pkg::SLOTS_TWO;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ src/alkq_decode.sv @@
// ----------------------------------------------------------------------------
// Keypad ladder decoder
// Maps an ADC reading to a key slot using the threshold set for 2, 3 or 4 keys.
// ----------------------------------------------------------------------------
module alkq_decode (
  input  logic [alkq_pkg::ADC_W-1:0]  adc,
  input  logic [alkq_pkg::SLOT_W-1:0] slots,
  output logic [alkq_pkg::SLOT_W-1:0] slot
);

  always_comb begin
    slot = alkq_pkg::NO_KEY;
    if (adc <= alkq_pkg::NONE_LIMIT) begin
      case (slots)
        alkq_pkg::SLOTS_TWO: begin
          if (adc > alkq_pkg::TWO_NONE)    slot = alkq_pkg::NO_KEY;
          else if (adc < alkq_pkg::TWO_LO) slot = 3'd0;
          else                             slot = 3'd1;
        end
        alkq_pkg::SLOTS_THREE: begin
          if (adc > alkq_pkg::THREE_NONE)      slot = alkq_pkg::NO_KEY;
          else if (adc < alkq_pkg::THREE_LO)   slot = 3'd0;
          else if (adc < alkq_pkg::THREE_MID)  slot = 3'd1;
          else                                 slot = 3'd2;
        end
        alkq_pkg::SLOTS_FOUR: begin
          if (adc < alkq_pkg::FOUR_LO)       slot = 3'd0;
          else if (adc < alkq_pkg::FOUR_MID) slot = 3'd1;
          else if (adc < alkq_pkg::FOUR_HI)  slot = 3'd2;
          else                               slot = 3'd3;
        end
        default: slot = alkq_pkg::NO_KEY; // unsupported ladder size
      endcase
    end
  end

endmodule

@@ src/alkq_core.sv @@
// ----------------------------------------------------------------------------
// Keypad qualifier core
// Per-channel key state and deadlines; computes the event for the registered
// sample and commits the state update when the sample moves to the output.
// ----------------------------------------------------------------------------
`include "analog_ladder_keypad_qualifier_top_macros.svh"

module alkq_core #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [alkq_pkg::TIME_W-1:0] time_now,
  input  logic [alkq_pkg::CH_W-1:0]   channel,
  input  logic [alkq_pkg::ADC_W-1:0]  adc_reading,
  input  alkq_pkg::cfg_t              cfg,
  output alkq_pkg::ev_kind_t          ev_kind,
  output logic [alkq_pkg::MASK_W-1:0] key_mask
);

  alkq_pkg::chan_st_t          st_r [NUM_CHANNELS];
  logic [alkq_pkg::TIME_W-1:0] shared_r;
  logic [alkq_pkg::TIME_W-1:0] shared_nxt;
  logic [alkq_pkg::TIME_W-1:0] idle_r;
  logic [alkq_pkg::TIME_W-1:0] idle_nxt;

  alkq_pkg::chan_st_t          cur;
  alkq_pkg::chan_st_t          st_nxt;
  logic [alkq_pkg::SLOT_W-1:0] oth_held;
  logic [alkq_pkg::MASK_W-1:0] oth_mask;
  logic                        ch_ok;
  logic [alkq_pkg::SLOT_W-1:0] slots;
  logic [alkq_pkg::SLOT_W-1:0] vk;
  logic [alkq_pkg::TIME_W-1:0] t_bounce;
  logic [alkq_pkg::TIME_W-1:0] t_long;
  logic [alkq_pkg::TIME_W-1:0] t_rpt;
  logic [alkq_pkg::TIME_W-1:0] t_idle;

  assign ch_ok = ({{(alkq_pkg::TIME_W-alkq_pkg::CH_W){1'b0}}, channel}
                  < alkq_pkg::TIME_W'(NUM_CHANNELS));
  assign slots = channel[0] ? cfg.slots_ch1 : cfg.slots_ch0;

  alkq_decode u_decode (
    .adc   (adc_reading),
    .slots (slots),
    .slot  (vk)
  );

  // state of the sampled channel and the held key of the other one
  always_comb begin
    cur      = alkq_pkg::CHAN_RST;
    oth_held = alkq_pkg::NO_KEY;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (alkq_pkg::CH_W'(c) == channel) cur      = st_r[c];
      else                              oth_held = st_r[c].held;
    end
    oth_mask = alkq_pkg::key_bit(~channel, oth_held);
  end

  assign t_bounce = time_now + alkq_pkg::TIME_W'(cfg.debounce);
  assign t_long   = time_now + alkq_pkg::TIME_W'(cfg.long_press);
  assign t_rpt    = time_now + alkq_pkg::TIME_W'(cfg.repeat_dly);
  assign t_idle   = time_now + cfg.inactivity;

  always_comb begin
    st_nxt     = cur;
    shared_nxt = shared_r;
    idle_nxt   = idle_r;
    ev_kind    = alkq_pkg::EV_NONE;
    key_mask   = '0;
    if (ch_ok && !(time_now < cur.bounce)) begin
      if (vk == cur.held) begin
        if (vk == alkq_pkg::NO_KEY) begin
          if (time_now >= idle_r) begin
            ev_kind  = alkq_pkg::EV_IDLE;
            key_mask = oth_mask;
            idle_nxt = t_idle;
          end
        end else if (cur.rpt != '0 && time_now >= cur.rpt) begin
          // shared gate keeps both channels from repeating too fast together
          if (time_now >= shared_r) begin
            ev_kind    = alkq_pkg::EV_REPEAT;
            key_mask   = alkq_pkg::key_bit(channel, vk) | oth_mask;
            shared_nxt = t_rpt;
          end
          st_nxt.rpt = t_rpt;
        end else if (cur.long_dl != '0 && time_now >= cur.long_dl) begin
          st_nxt.long_dl = '0;
          st_nxt.rpt     = t_rpt;
          ev_kind        = alkq_pkg::EV_LONG;
          key_mask       = alkq_pkg::key_bit(channel, vk) | oth_mask;
        end
      end else if (cur.bounce == '0) begin
        st_nxt.bounce = t_bounce;
      end else if (cur.held == alkq_pkg::NO_KEY) begin
        st_nxt.long_dl = t_long;
        st_nxt.rpt     = '0;
        st_nxt.bounce  = '0;
        st_nxt.held    = vk;
        ev_kind        = alkq_pkg::EV_DOWN;
        key_mask       = alkq_pkg::key_bit(channel, vk) | oth_mask;
        idle_nxt       = t_idle;
      end else if (vk == alkq_pkg::NO_KEY) begin
        st_nxt.long_dl = '0;
        st_nxt.rpt     = '0;
        st_nxt.bounce  = '0;
        st_nxt.held    = alkq_pkg::NO_KEY;
        ev_kind        = alkq_pkg::EV_UP;
        key_mask       = alkq_pkg::key_bit(channel, cur.held) | oth_mask;
        idle_nxt       = t_idle;
      end
      // key-to-key change is a transient: nothing moves
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        st_r[c] <= alkq_pkg::CHAN_RST;
      end
      shared_r <= '0;
      idle_r   <= alkq_pkg::INACTIVITY_RST;
    end else if (fire) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (ch_ok && alkq_pkg::CH_W'(c) == channel) st_r[c] <= st_nxt;
      end
      shared_r <= shared_nxt;
      idle_r   <= idle_nxt;
    end
  end

  `ALKQ_ASSERT_IMP(a_held_range, clk, rst_n, 1'b1, st_r[0].held <= alkq_pkg::NO_KEY, "held key out of range")
  `ALKQ_ASSERT_NXT(a_down_arms_long, clk, rst_n, fire && ev_kind == alkq_pkg::EV_DOWN && channel == 1'b0, st_r[0].held != alkq_pkg::NO_KEY && st_r[0].bounce == '0, "key down did not latch key")
  `ALKQ_ASSERT_IMP(a_none_no_mask, clk, rst_n, ev_kind == alkq_pkg::EV_NONE, key_mask == '0, "mask set without event")

endmodule

@@ src/analog_ladder_keypad_qualifier_top.sv @@
// ----------------------------------------------------------------------------
// Analog ladder keypad qualifier
// Decodes resistor-ladder keypad samples and qualifies them into key down,
// key up, long press, auto-repeat and inactivity events.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  -------  ---------------------  --------------------------------------
//  in       in_valid / in_stall    in_time_now, in_channel, in_adc_reading
//  out      out_valid / out_stall  out_event_kind, out_key_mask
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle sustained while the output is not stalled; a sample
// goes from the input register through one pass of decode and qualification
// logic into the result register.
// Reset (rst_n low, synchronous) restores register defaults and clears all
// key state; no clearing pass is needed.
// A stall on the output holds the result register; the input register keeps
// accepting until it also holds a sample, then in_stall rises.
// ----------------------------------------------------------------------------
`include "analog_ladder_keypad_qualifier_top_macros.svh"

module analog_ladder_keypad_qualifier_top #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [alkq_pkg::TIME_W-1:0] in_time_now,
  input  logic [alkq_pkg::CH_W-1:0]   in_channel,
  input  logic [alkq_pkg::ADC_W-1:0]  in_adc_reading,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_event_kind,
  output logic [alkq_pkg::MASK_W-1:0] out_key_mask,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [alkq_pkg::CIDX_W-1:0] cfg_index,
  input  logic [alkq_pkg::TIME_W-1:0] cfg_data
);

  logic                        in_vld_r;
  logic                        in_vld_nxt;
  logic [alkq_pkg::TIME_W-1:0] in_time_r;
  logic [alkq_pkg::CH_W-1:0]   in_ch_r;
  logic [alkq_pkg::ADC_W-1:0]  in_adc_r;
  logic                        out_vld_r;
  logic                        out_vld_nxt;
  alkq_pkg::ev_kind_t          out_kind_r;
  logic [alkq_pkg::MASK_W-1:0] out_mask_r;

  logic                        in_acc;
  logic                        fire;
  alkq_pkg::cfg_t              cfg;
  alkq_pkg::ev_kind_t          ev_kind;
  logic [alkq_pkg::MASK_W-1:0] ev_mask;

  alkq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  alkq_core #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .time_now    (in_time_r),
    .channel     (in_ch_r),
    .adc_reading (in_adc_r),
    .cfg         (cfg),
    .ev_kind     (ev_kind),
    .key_mask    (ev_mask)
  );

  // sample moves to the result register unless a held result blocks it
  assign fire     = in_vld_r && !(out_vld_r && out_stall);
  assign in_stall = in_vld_r && !fire;
  assign in_acc   = in_valid && !in_stall;

  assign in_vld_nxt  = in_acc || (in_vld_r && !fire);
  assign out_vld_nxt = fire || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_time_r <= in_time_now;
      in_ch_r   <= in_channel;
      in_adc_r  <= in_adc_reading;
    end
    if (fire) begin
      out_kind_r <= ev_kind;
      out_mask_r <= ev_mask;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_event_kind = out_kind_r;
  assign out_key_mask   = out_mask_r;

  `ALKQ_ASSERT_NXT(a_fire_loads_out, clk, rst_n, fire, out_vld_r, "result lost after fire")
  `ALKQ_ASSERT_IMP(a_none_zero_mask, clk, rst_n, out_vld_r && out_kind_r == alkq_pkg::EV_NONE, out_mask_r == '0, "mask on empty result")
  `ALKQ_ASSERT_IMP(a_key_event_mask, clk, rst_n, out_vld_r && (out_kind_r == alkq_pkg::EV_DOWN || out_kind_r == alkq_pkg::EV_UP || out_kind_r == alkq_pkg::EV_LONG || out_kind_r == alkq_pkg::EV_REPEAT), out_mask_r != '0, "key event without key")
  `ALKQ_ASSERT_IMP(a_free_in_no_stall, clk, rst_n, !out_vld_r, !in_stall, "stall with empty result register")

endmodule
